// File: src/mtcb_pkg.sv
// ----------------------------------------------------------------------------
// mtcb_pkg
// shared types, sizes and codes of the monotone table center search
// ----------------------------------------------------------------------------
package mtcb_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 1024;
   localparam int VALUE_BITS  = 32;
   localparam int ROW_FIELDS  = 8;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = IDX_W + 1;
   localparam int ROW_W       = ROW_FIELDS * VALUE_BITS;

   // slant height arithmetic
   localparam int SLANT_SHIFT = 14;
   localparam int ANGLE_W     = 16;
   localparam int PROD_W      = VALUE_BITS + ANGLE_W;
   localparam int KEY_W       = VALUE_BITS + 3;

   // fixed port widths
   localparam int USED_W      = 11;
   localparam int CENTER_W    = 10;
   localparam int MIN_ROWS    = 3;

   // width that holds both the row count and the register value
   localparam int SAT_W       = (CNT_W > USED_W) ? CNT_W : USED_W;

   // field positions inside a row
   localparam logic [2:0] FIELD_TIME  = 3'd0;
   localparam logic [2:0] FIELD_MACH  = 3'd1;
   localparam logic [2:0] FIELD_POS_X = 3'd2;
   localparam logic [2:0] FIELD_POS_Y = 3'd3;
   localparam logic [2:0] FIELD_POS_Z = 3'd4;
   localparam logic [2:0] FIELD_VEL_X = 3'd5;
   localparam logic [2:0] FIELD_VEL_Y = 3'd6;
   localparam logic [2:0] FIELD_VEL_Z = 3'd7;

   // commands
   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_FIELD = 2'd1;
   localparam logic [1:0] CMD_SLANT = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_USED_ENTRIES = 2'd0;
   localparam logic [1:0] CSR_COS_LOOK     = 2'd1;
   localparam logic [1:0] CSR_SIN_LOOK     = 2'd2;

   localparam logic signed [ANGLE_W-1:0] COS_RESET = 16'sd16384;
   localparam logic signed [ANGLE_W-1:0] SIN_RESET = 16'sd0;

   typedef logic [ROW_FIELDS-1:0][VALUE_BITS-1:0] row_type;

   typedef struct packed {
      logic [1:0]         command;
      logic [9:0]         row_index;
      logic signed [31:0] row_time;
      logic signed [31:0] row_mach;
      logic signed [31:0] row_pos_x;
      logic signed [31:0] row_pos_y;
      logic signed [31:0] row_pos_z;
      logic signed [31:0] row_vel_x;
      logic signed [31:0] row_vel_y;
      logic signed [31:0] row_vel_z;
      logic [2:0]         key_field;
      logic signed [31:0] search_value;
   } req_word_type;

   typedef struct packed {
      logic [CENTER_W-1:0] center_index;
      logic                too_few_rows;
   } rsp_word_type;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_READ = 5'b00010,
      ST_KEY  = 5'b00100,
      ST_EVAL = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   typedef enum logic [1:0] {
      PROBE_LAST,
      PROBE_FIRST,
      PROBE_MID
   } probe_type;

endpackage

// File: src/mtcb_ram.sv
// ----------------------------------------------------------------------------
// mtcb_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module mtcb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/monotone_table_center_bisect_top.sv
// ----------------------------------------------------------------------------
// monotone_table_center_bisect_top
// trajectory row table with lower-bound bisection and center clamping
// ----------------------------------------------------------------------------
// A write word stores one row of eight Q16.16 values in a single 1024 x 256
// ram. A search word bisects the first used_entries rows by one field or by
// the slant height py*cos - px*sin and returns the lower-bound row clamped
// to 1..n-2, or flags a table of fewer than three rows. Every memory probe
// goes through a ram read, a key/multiply stage and a compare stage, and a
// search makes two end probes plus up to ceil(log2(n)) bisection probes; a
// flagged search makes no probes. The block works on one search at a time
// and the result sits in an output register, so the next word is taken
// while an earlier result still waits. Rows must be written before a search
// reads them; the ram has no reset.
// ----------------------------------------------------------------------------
module monotone_table_center_bisect_top
   import mtcb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   // response channel
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word,
   // register write channel
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_data
);

   // control and configuration
   state_type                  state_ff, state_in;
   probe_type                  probe_ff, probe_in;
   logic [USED_W-1:0]          used_entries_ff;
   logic signed [ANGLE_W-1:0]  cos_look_ff;
   logic signed [ANGLE_W-1:0]  sin_look_ff;
   logic                       rsp_valid_ff, rsp_valid_in;

   // search payload
   logic [CNT_W-1:0]           n_ff, n_in;
   logic [IDX_W-1:0]           lo_ff, lo_in;
   logic [IDX_W-1:0]           hi_ff, hi_in;
   logic                       slant_ff, slant_in;
   logic [2:0]                 key_field_ff, key_field_in;
   logic signed [KEY_W-1:0]    target_ff, target_in;
   logic signed [KEY_W-1:0]    key_last_ff, key_last_in;
   logic                       increasing_ff, increasing_in;
   logic signed [PROD_W-1:0]   prod_a_ff, prod_a_in;
   logic signed [PROD_W-1:0]   prod_b_ff, prod_b_in;
   logic [IDX_W-1:0]           res_index_ff, res_index_in;
   logic                       res_few_ff, res_few_in;
   rsp_word_type               rsp_word_ff, rsp_word_in;

   // combinational helpers
   logic                       req_take;
   logic                       csr_take;
   logic [SAT_W-1:0]           used_ext;
   logic [CNT_W-1:0]           n_sat;
   logic [IDX_W-1:0]           mid;
   logic [IDX_W-1:0]           n_minus_one;
   logic [IDX_W-1:0]           n_minus_two;
   logic signed [KEY_W-1:0]    key_now;
   logic                       go_right;
   logic                       out_free;

   // ram side
   logic                       ram_wr_en;
   logic [IDX_W-1:0]           ram_wr_addr;
   row_type                    ram_wr_row;
   logic                       ram_rd_en;
   logic [IDX_W-1:0]           ram_rd_addr;
   row_type                    ram_rd_row;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign csr_take  = csr_valid && csr_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // output slot can take a new word this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // row count saturates at the table depth
   assign used_ext = SAT_W'(used_entries_ff);
   assign n_sat    = (used_ext > SAT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                      : CNT_W'(used_ext);

   assign n_minus_one = IDX_W'(n_ff - CNT_W'(1));
   assign n_minus_two = IDX_W'(n_ff - CNT_W'(2));
   assign mid         = lo_ff + ((hi_ff - lo_ff) >> 1);

   // key from the registered products: floor shifts then exact difference
   assign key_now = KEY_W'(prod_a_ff >>> SLANT_SHIFT)
                  - KEY_W'(prod_b_ff >>> SLANT_SHIFT);
   assign go_right = increasing_ff ? (key_now < target_ff) : (key_now > target_ff);

   // row write straight from the request word
   always_comb begin
      ram_wr_row              = '0;
      ram_wr_row[FIELD_TIME]  = VALUE_BITS'(req_word.row_time);
      ram_wr_row[FIELD_MACH]  = VALUE_BITS'(req_word.row_mach);
      ram_wr_row[FIELD_POS_X] = VALUE_BITS'(req_word.row_pos_x);
      ram_wr_row[FIELD_POS_Y] = VALUE_BITS'(req_word.row_pos_y);
      ram_wr_row[FIELD_POS_Z] = VALUE_BITS'(req_word.row_pos_z);
      ram_wr_row[FIELD_VEL_X] = VALUE_BITS'(req_word.row_vel_x);
      ram_wr_row[FIELD_VEL_Y] = VALUE_BITS'(req_word.row_vel_y);
      ram_wr_row[FIELD_VEL_Z] = VALUE_BITS'(req_word.row_vel_z);
   end

   // writes beyond the table depth are dropped
   assign ram_wr_en   = req_take && (req_word.command == CMD_WRITE)
                     && (32'(req_word.row_index) < 32'(TABLE_DEPTH));
   assign ram_wr_addr = IDX_W'(req_word.row_index);

   mtcb_ram #(
      .WIDTH (ROW_W),
      .DEPTH (TABLE_DEPTH)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_row),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_row)
   );

   // search sequencer
   always_comb begin
      state_in      = state_ff;
      probe_in      = probe_ff;
      rsp_valid_in  = rsp_valid_ff;
      n_in          = n_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      slant_in      = slant_ff;
      key_field_in  = key_field_ff;
      target_in     = target_ff;
      key_last_in   = key_last_ff;
      increasing_in = increasing_ff;
      prod_a_in     = prod_a_ff;
      prod_b_in     = prod_b_ff;
      res_index_in  = res_index_ff;
      res_few_in    = res_few_ff;
      rsp_word_in   = rsp_word_ff;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = '0;

      // waiting word leaves
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take && ((req_word.command == CMD_FIELD) ||
                             (req_word.command == CMD_SLANT))) begin
               slant_in     = (req_word.command == CMD_SLANT);
               key_field_in = req_word.key_field;
               target_in    = KEY_W'(VALUE_BITS'(req_word.search_value));
               n_in         = n_sat;
               lo_in        = '0;
               hi_in        = IDX_W'(n_sat - CNT_W'(1));
               probe_in     = PROBE_LAST;
               if (n_sat < CNT_W'(MIN_ROWS)) begin
                  res_few_in   = 1'b1;
                  res_index_in = '0;
                  state_in     = ST_DONE;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            case (probe_ff)
               PROBE_LAST: begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = n_minus_one;
                  state_in    = ST_KEY;
               end
               PROBE_FIRST: begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = '0;
                  state_in    = ST_KEY;
               end
               default: begin
                  if (lo_ff < hi_ff) begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = mid;
                     state_in    = ST_KEY;
                  end else begin
                     // bisection done, clamp to a center row
                     res_few_in = 1'b0;
                     if (lo_ff == '0) begin
                        res_index_in = IDX_W'(1);
                     end else if (lo_ff > n_minus_two) begin
                        res_index_in = n_minus_two;
                     end else begin
                        res_index_in = lo_ff;
                     end
                     state_in = ST_DONE;
                  end
               end
            endcase
         end
         ST_KEY: begin
            // field keys ride the same path pre-scaled so the shift undoes it
            if (slant_ff) begin
               prod_a_in = PROD_W'(signed'(ram_rd_row[FIELD_POS_Y])) * PROD_W'(cos_look_ff);
               prod_b_in = PROD_W'(signed'(ram_rd_row[FIELD_POS_X])) * PROD_W'(sin_look_ff);
            end else begin
               prod_a_in = PROD_W'(signed'(ram_rd_row[key_field_ff])) <<< SLANT_SHIFT;
               prod_b_in = '0;
            end
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            case (probe_ff)
               PROBE_LAST: begin
                  key_last_in = key_now;
                  probe_in    = PROBE_FIRST;
               end
               PROBE_FIRST: begin
                  increasing_in = (key_last_ff >= key_now);
                  probe_in      = PROBE_MID;
               end
               default: begin
                  if (go_right) begin
                     lo_in = mid + IDX_W'(1);
                  end else begin
                     hi_in = mid;
                  end
               end
            endcase
            state_in = ST_READ;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_word_in.center_index = CENTER_W'(res_index_ff);
               rsp_word_in.too_few_rows = res_few_ff;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         probe_ff        <= PROBE_LAST;
         rsp_valid_ff    <= 1'b0;
         used_entries_ff <= '0;
         cos_look_ff     <= COS_RESET;
         sin_look_ff     <= SIN_RESET;
      end else begin
         state_ff     <= state_in;
         probe_ff     <= probe_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_take) begin
            case (csr_index)
               CSR_USED_ENTRIES: used_entries_ff <= USED_W'(csr_data);
               CSR_COS_LOOK:     cos_look_ff     <= signed'(csr_data);
               CSR_SIN_LOOK:     sin_look_ff     <= signed'(csr_data);
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      n_ff          <= n_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      slant_ff      <= slant_in;
      key_field_ff  <= key_field_in;
      target_ff     <= target_in;
      key_last_ff   <= key_last_in;
      increasing_ff <= increasing_in;
      prod_a_ff     <= prod_a_in;
      prod_b_ff     <= prod_b_in;
      res_index_ff  <= res_index_in;
      res_few_ff    <= res_few_in;
      rsp_word_ff   <= rsp_word_in;
   end

endmodule

// File: tb/monotone_table_center_bisect_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// monotone_table_center_bisect_checker
// watches the request, response and register channels of the center search,
// keeps its own copy of the row table and registers, predicts the center row
// of every accepted search and compares each response word field by field
// ----------------------------------------------------------------------------
module monotone_table_center_bisect_checker
   import mtcb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  req_word_type req_word,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  rsp_word_type rsp_word,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_data,
   output int           searches_in_flight,
   output int           mismatch_count
);

   logic signed [VALUE_BITS-1:0] row_copy [TABLE_DEPTH][ROW_FIELDS];
   logic [USED_W-1:0]            used_rows;
   logic signed [ANGLE_W-1:0]    cos_q;
   logic signed [ANGLE_W-1:0]    sin_q;
   rsp_word_type                 expected_centers [$];

   // key of one row: a plain field, or py*cos - px*sin with floored products
   function automatic longint row_key(int row, bit slant, logic [2:0] field);
      longint py_term;
      longint px_term;
      if (!slant) return longint'(row_copy[row][field]);
      py_term = (longint'(row_copy[row][FIELD_POS_Y]) * longint'(cos_q)) >>> SLANT_SHIFT;
      px_term = (longint'(row_copy[row][FIELD_POS_X]) * longint'(sin_q)) >>> SLANT_SHIFT;
      return py_term - px_term;
   endfunction

   // lower-bound bisection over the first n rows, clamped to 1..n-2
   function automatic rsp_word_type predict_center(bit slant, logic [2:0] field,
                                                   logic signed [31:0] target);
      rsp_word_type res;
      int           n;
      int           lo;
      int           hi;
      int           mid;
      bit           rising;
      bit           go_right;
      longint       probe;
      res = '0;
      n = int'(used_rows);
      if (n > TABLE_DEPTH) n = TABLE_DEPTH;
      if (n < MIN_ROWS) begin
         res.too_few_rows = 1'b1;
         return res;
      end
      rising = row_key(n - 1, slant, field) >= row_key(0, slant, field);
      lo = 0;
      hi = n - 1;
      while (lo < hi) begin
         mid = lo + ((hi - lo) >> 1);
         probe = row_key(mid, slant, field);
         go_right = rising ? (probe < longint'(target)) : (probe > longint'(target));
         if (go_right) lo = mid + 1;
         else hi = mid;
      end
      if (lo < 1) lo = 1;
      if (lo > n - 2) lo = n - 2;
      res.center_index = lo[CENTER_W-1:0];
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         used_rows = '0;
         cos_q = COS_RESET;
         sin_q = SIN_RESET;
         expected_centers.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_USED_ENTRIES: used_rows = csr_data[USED_W-1:0];
               CSR_COS_LOOK:     cos_q = csr_data;
               CSR_SIN_LOOK:     sin_q = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_centers.size() == 0) begin
               $error("response word with no search outstanding: center_index %0d too_few_rows %0d",
                      rsp_word.center_index, rsp_word.too_few_rows);
               mismatch_count++;
            end else begin
               want = expected_centers.pop_front();
               if (rsp_word.center_index !== want.center_index) begin
                  $error("center_index: expected %0d, got %0d",
                         want.center_index, rsp_word.center_index);
                  mismatch_count++;
               end
               if (rsp_word.too_few_rows !== want.too_few_rows) begin
                  $error("too_few_rows: expected %0d, got %0d",
                         want.too_few_rows, rsp_word.too_few_rows);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            case (req_word.command)
               CMD_WRITE: begin
                  row_copy[req_word.row_index][FIELD_TIME]  = req_word.row_time;
                  row_copy[req_word.row_index][FIELD_MACH]  = req_word.row_mach;
                  row_copy[req_word.row_index][FIELD_POS_X] = req_word.row_pos_x;
                  row_copy[req_word.row_index][FIELD_POS_Y] = req_word.row_pos_y;
                  row_copy[req_word.row_index][FIELD_POS_Z] = req_word.row_pos_z;
                  row_copy[req_word.row_index][FIELD_VEL_X] = req_word.row_vel_x;
                  row_copy[req_word.row_index][FIELD_VEL_Y] = req_word.row_vel_y;
                  row_copy[req_word.row_index][FIELD_VEL_Z] = req_word.row_vel_z;
               end
               CMD_FIELD:
                  expected_centers.push_back(predict_center(1'b0, req_word.key_field,
                                                            req_word.search_value));
               CMD_SLANT:
                  expected_centers.push_back(predict_center(1'b1, req_word.key_field,
                                                            req_word.search_value));
               default: ;
            endcase
         end
      end
      searches_in_flight = expected_centers.size();
   end

endmodule

// File: tb/monotone_table_center_bisect_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// monotone_table_center_bisect_top_test
// stimulus and verdict for the trajectory table center search
// ----------------------------------------------------------------------------
// Runs a short directed part (empty and tiny tables, unused command, rows at
// the corners of the value range, every key field, slant height at extreme
// angles), then phases of random words over monotone tables of many sizes,
// oversized and masked row counts, plateaus and broken rows, under several
// sender and receiver idling patterns and one long receiver hold. A separate
// checker predicts and compares every response word.
// ----------------------------------------------------------------------------
module monotone_table_center_bisect_top_test;
   import mtcb_pkg::*;

   // command code with no function in the block
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam int CLOCK_PERIOD = 20;
   localparam int RESET_CYCLES = 6;
   // outlasts the longest search, so this covers any word still in work
   localparam int DRAIN_CYCLES = 50;
   localparam int LIMIT_CYCLES = 1_500_000;
   localparam int ROW_STEP     = 1 << 21;
   localparam int PLATEAU_STEP = 1 << 23;
   localparam int HOLD_STRETCH = 400;

   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic [15:0] ANGLE_ONE     = 16'h4000;
   localparam logic [15:0] ANGLE_NEG_ONE = 16'hC000;

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   logic         csr_valid;
   logic         csr_ready;
   logic [1:0]   csr_index;
   logic [15:0]  csr_data;

   int searches_in_flight;
   int mismatch_count;

   // idling knobs, percent per cycle
   int sender_gap_pct     = 0;
   int receiver_stall_pct = 0;
   // cycles left in a forced receiver hold
   int hold_cycles        = 0;

   // what has been written, for picking exact-hit search targets
   logic signed [31:0]    shadow_rows [TABLE_DEPTH][ROW_FIELDS];
   // rows the current table covers, after saturation
   int                    table_rows = 0;
   // per-field direction of the ramp: set bit means falling
   logic [ROW_FIELDS-1:0] field_falls = '0;
   // runs of four equal keys instead of a strict ramp
   bit                    plateau_rows = 1'b0;

   monotone_table_center_bisect_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   monotone_table_center_bisect_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_word           (req_word),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_word           (rsp_word),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .searches_in_flight (searches_in_flight),
      .mismatch_count     (mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #(LIMIT_CYCLES * CLOCK_PERIOD);
      $display("FAIL");
      $finish;
   end

   // receiver side: forced hold first, then random stalls
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall = 1'b1;
         hold_cycles--;
      end else begin
         rsp_stall = ($urandom_range(99) < receiver_stall_pct);
      end
   end

   // every field random, command included
   function automatic req_word_type noise_word();
      req_word_type w;
      w.command      = $urandom_range(3);
      w.row_index    = $urandom_range(TABLE_DEPTH - 1);
      w.row_time     = $urandom;
      w.row_mach     = $urandom;
      w.row_pos_x    = $urandom;
      w.row_pos_y    = $urandom;
      w.row_pos_z    = $urandom;
      w.row_vel_x    = $urandom;
      w.row_vel_y    = $urandom;
      w.row_vel_z    = $urandom;
      w.key_field    = $urandom_range(7);
      w.search_value = $urandom;
      return w;
   endfunction

   // one field of a monotone row, rising or falling by field
   function automatic logic signed [31:0] ramp_value(int row, logic [2:0] field);
      int base;
      if (plateau_rows) base = ((row >> 2) - 128) * PLATEAU_STEP;
      else base = (row - 512) * ROW_STEP + int'($urandom_range(ROW_STEP / 2 - 1));
      return field_falls[field] ? -base : base;
   endfunction

   function automatic req_word_type ramp_word(int row);
      req_word_type w;
      w = noise_word();
      w.command   = CMD_WRITE;
      w.row_index = row[9:0];
      w.row_time  = ramp_value(row, FIELD_TIME);
      w.row_mach  = ramp_value(row, FIELD_MACH);
      w.row_pos_x = ramp_value(row, FIELD_POS_X);
      w.row_pos_y = ramp_value(row, FIELD_POS_Y);
      w.row_pos_z = ramp_value(row, FIELD_POS_Z);
      w.row_vel_x = ramp_value(row, FIELD_VEL_X);
      w.row_vel_y = ramp_value(row, FIELD_VEL_Y);
      w.row_vel_z = ramp_value(row, FIELD_VEL_Z);
      return w;
   endfunction

   // write word with the same value in all eight fields
   function automatic req_word_type flat_row_word(int row, logic signed [31:0] value);
      req_word_type w;
      w = noise_word();
      w.command   = CMD_WRITE;
      w.row_index = row[9:0];
      w.row_time  = value;
      w.row_mach  = value;
      w.row_pos_x = value;
      w.row_pos_y = value;
      w.row_pos_z = value;
      w.row_vel_x = value;
      w.row_vel_y = value;
      w.row_vel_z = value;
      return w;
   endfunction

   function automatic req_word_type search_word(logic [1:0] cmd, logic [2:0] field,
                                                logic signed [31:0] target);
      req_word_type w;
      w = noise_word();
      w.command      = cmd;
      w.key_field    = field;
      w.search_value = target;
      return w;
   endfunction

   // targets: exact keys, values inside the table span, anything, extremes
   function automatic req_word_type random_search();
      logic [1:0]         cmd;
      logic [2:0]         field;
      logic signed [31:0] target;
      int                 pick;
      cmd   = ($urandom_range(99) < 70) ? CMD_FIELD : CMD_SLANT;
      field = $urandom_range(7);
      pick  = $urandom_range(99);
      if (pick < 40 && table_rows >= MIN_ROWS)
         target = shadow_rows[$urandom_range(table_rows - 1)]
                             [(cmd == CMD_SLANT) ? FIELD_POS_Y : field];
      else if (pick < 80)
         target = int'($urandom_range(32'h7FFF_FFFF)) - (1 << 30);
      else if (pick < 90)
         target = $urandom;
      else
         target = pick[0] ? Q_MAX : Q_MIN;
      return search_word(cmd, field, target);
   endfunction

   // offer one word with random gaps ahead, wait for the handshake
   task automatic send_word(input req_word_type w);
      while ($urandom_range(99) < sender_gap_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_word  = w;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      if (w.command == CMD_WRITE) begin
         shadow_rows[w.row_index][FIELD_TIME]  = w.row_time;
         shadow_rows[w.row_index][FIELD_MACH]  = w.row_mach;
         shadow_rows[w.row_index][FIELD_POS_X] = w.row_pos_x;
         shadow_rows[w.row_index][FIELD_POS_Y] = w.row_pos_y;
         shadow_rows[w.row_index][FIELD_POS_Z] = w.row_pos_z;
         shadow_rows[w.row_index][FIELD_VEL_X] = w.row_vel_x;
         shadow_rows[w.row_index][FIELD_VEL_Y] = w.row_vel_y;
         shadow_rows[w.row_index][FIELD_VEL_Z] = w.row_vel_z;
      end
   endtask

   // wait for every search answer, then for any write still in work
   task automatic wait_drained();
      req_valid = 1'b0;
      while (searches_in_flight != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic put_csr(input logic [1:0] idx, input logic [15:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // all three registers, only once the block is idle
   task automatic configure(input logic [15:0] used_value, input logic [15:0] cos_value,
                            input logic [15:0] sin_value);
      wait_drained();
      put_csr(CSR_USED_ENTRIES, used_value);
      put_csr(CSR_COS_LOOK, cos_value);
      put_csr(CSR_SIN_LOOK, sin_value);
      table_rows = (int'(used_value[USED_W-1:0]) > TABLE_DEPTH) ?
                   TABLE_DEPTH : int'(used_value[USED_W-1:0]);
   endtask

   task automatic fill_rows(input int count);
      for (int r = 0; r < count; r++) send_word(ramp_word(r));
   endtask

   // mostly searches and ramp rewrites, some broken rows and unused commands
   task automatic run_random(input int count);
      req_word_type w;
      int           done;
      int           pick;
      int           row;
      done = 0;
      while (done < count) begin
         pick = $urandom_range(99);
         row  = $urandom_range((table_rows > 0) ? table_rows - 1 : 0);
         if (pick < 60) begin
            w = random_search();
         end else if (pick < 85) begin
            w = ramp_word(row);
         end else if (pick < 95) begin
            w = noise_word();
            w.command = CMD_WRITE;
         end else begin
            w = noise_word();
            w.command = CMD_UNUSED;
         end
         send_word(w);
         if (w.command != CMD_UNUSED) done++;
      end
   endtask

   task automatic run_phase(input logic [15:0] used_value, input logic [15:0] cos_value,
                            input logic [15:0] sin_value, input idle_mode_type mode,
                            input bit refill, input int count);
      configure(used_value, cos_value, sin_value);
      case (mode)
         IDLE_NONE:     begin sender_gap_pct = 0;  receiver_stall_pct = 0;  end
         IDLE_SENDER:   begin sender_gap_pct = 50; receiver_stall_pct = 0;  end
         IDLE_RECEIVER: begin sender_gap_pct = 0;  receiver_stall_pct = 50; end
         default:       begin sender_gap_pct = 17; receiver_stall_pct = 17; end
      endcase
      if (refill) begin
         field_falls  = $urandom;
         plateau_rows = ($urandom_range(3) == 0);
         fill_rows(table_rows);
      end
      run_random(count);
   endtask

   function automatic logic [15:0] rand_angle();
      return 16'(int'($urandom_range(32768)) - 16384);
   endfunction

   initial begin
      req_word_type w;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_word  = '0;
      csr_valid = 1'b0;
      csr_index = CSR_USED_ENTRIES;
      csr_data  = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty table straight after reset: both searches flagged
      send_word(search_word(CMD_FIELD, FIELD_TIME, Q_MAX));
      send_word(search_word(CMD_SLANT, FIELD_TIME, Q_MIN));
      // unused command, no response word
      w = noise_word();
      w.command = CMD_UNUSED;
      send_word(w);

      // three rows at the corners of the value range, middle row mixed
      send_word(flat_row_word(0, Q_MIN));
      w = flat_row_word(1, 32'sd0);
      w.row_mach  = -32'sd1;
      w.row_pos_x = 32'sd1;
      w.row_pos_y = -32'sd1;
      w.row_vel_x = 32'sh5555_5555;
      w.row_vel_y = 32'shAAAA_AAAA;
      send_word(w);
      send_word(flat_row_word(2, Q_MAX));

      // one and two rows: still too few
      configure(16'd1, ANGLE_ONE, 16'd0);
      send_word(search_word(CMD_FIELD, FIELD_MACH, 32'sd0));
      configure(16'd2, ANGLE_ONE, 16'd0);
      send_word(search_word(CMD_SLANT, FIELD_MACH, 32'sd0));

      // three rows: every key field, targets at the extremes and around zero
      configure(16'd3, ANGLE_ONE, 16'd0);
      for (int f = 0; f < ROW_FIELDS; f++) begin
         case (f % 4)
            0: send_word(search_word(CMD_FIELD, f[2:0], Q_MIN));
            1: send_word(search_word(CMD_FIELD, f[2:0], Q_MAX));
            2: send_word(search_word(CMD_FIELD, f[2:0], 32'sd0));
            default: send_word(search_word(CMD_FIELD, f[2:0], -32'sd1));
         endcase
      end
      send_word(search_word(CMD_SLANT, FIELD_TIME, 32'sd0));

      // slant height at extreme angles, widest differences and negative products
      configure(16'd3, ANGLE_NEG_ONE, ANGLE_ONE);
      send_word(search_word(CMD_SLANT, FIELD_TIME, Q_MIN));
      send_word(search_word(CMD_SLANT, FIELD_TIME, Q_MAX));
      configure(16'd3, ANGLE_ONE, ANGLE_NEG_ONE);
      send_word(search_word(CMD_SLANT, FIELD_TIME, 32'sd0));

      // full table first, large sizes before the small refills overwrite the ramp
      run_phase(16'd1024, ANGLE_ONE, 16'd0, IDLE_NONE, 1'b1, 40);
      // oversized counts saturate to the table depth
      run_phase(16'd2047, rand_angle(), rand_angle(), IDLE_SENDER, 1'b0, 30);
      run_phase(16'd1025, ANGLE_NEG_ONE, ANGLE_ONE, IDLE_RECEIVER, 1'b0, 30);
      // high data bits above the count field are dropped
      run_phase(16'hFC00, rand_angle(), rand_angle(), IDLE_BOTH, 1'b0, 30);

      // long receiver hold: results back up, the block fills and stalls its input
      wait_drained();
      sender_gap_pct     = 0;
      receiver_stall_pct = 0;
      hold_cycles        = HOLD_STRETCH;
      repeat (20) send_word(random_search());

      // small tables, fresh ramps with new directions
      run_phase(16'd3, rand_angle(), rand_angle(), IDLE_BOTH, 1'b1, 25);
      run_phase(16'd4, rand_angle(), rand_angle(), IDLE_NONE, 1'b1, 25);
      run_phase(16'd5, rand_angle(), rand_angle(), IDLE_SENDER, 1'b1, 25);
      run_phase(16'($urandom_range(40, 6)), rand_angle(), rand_angle(), IDLE_RECEIVER,
                1'b1, 25);
      run_phase(16'($urandom_range(64, 3)), rand_angle(), rand_angle(), IDLE_BOTH,
                1'b1, 25);
      // two rows again: flagged searches among writes
      run_phase(16'd2, rand_angle(), rand_angle(), IDLE_NONE, 1'b0, 10);
      // masked count of three
      run_phase(16'hF803, ANGLE_ONE, ANGLE_NEG_ONE, IDLE_RECEIVER, 1'b1, 20);

      wait_drained();
      if (mismatch_count == 0 && searches_in_flight == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: sim.f
src/mtcb_pkg.sv
src/mtcb_ram.sv
src/monotone_table_center_bisect_top.sv
tb/monotone_table_center_bisect_checker.sv
tb/monotone_table_center_bisect_top_test.sv
